### rtl/core/tqs_pkg.sv
// Shared types and constants for the timer queue scheduler.
// Used by tqs_ctrl, tqs_datapath, timer_queue_scheduler and tqs_checker.
`timescale 1ns / 1ps
package tqs_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int PERIOD_BITS_DEF = 24;

    localparam int ID_W      = 31;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int PER_W     = 24;
    localparam int PER_LSB   = 0;
    localparam int PERIODIC_BIT = 24;
    localparam int TID_LSB   = 25;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] EV_ADDED = 2'd0;
    localparam logic [KIND_W-1:0] EV_FIRED = 2'd1;
    localparam logic [KIND_W-1:0] EV_FULL  = 2'd2;

    typedef enum logic [1:0] {
        SCAN_REMOVE,
        SCAN_TICK,
        SCAN_SELECT
    } scan_mode_t;

    typedef struct packed {
        logic       capture;
        logic       scan_start;
        scan_mode_t mode;
        logic       add_exec;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic fired_any;
        logic out_free;
        logic sel_last;
    } sts_t;

endpackage

### rtl/core/tqs_ctrl.sv
// Sequencer for the timer queue scheduler: decodes the op of each input
// transaction and steps the datapath through add, remove and tick scans. Uses tqs_pkg.
`timescale 1ns / 1ps
module tqs_ctrl import tqs_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] s_op,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_RM_SCAN,
        ST_TICK_SCAN,
        ST_SEL_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        OP_ADD: state_next = ST_ADD;
                        OP_REMOVE: begin
                            cmd.scan_start = 1'b1;
                            cmd.mode       = SCAN_REMOVE;
                            state_next     = ST_RM_SCAN;
                        end
                        OP_TICK: begin
                            cmd.scan_start = 1'b1;
                            cmd.mode       = SCAN_TICK;
                            state_next     = ST_TICK_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (sts.out_free) begin
                    cmd.add_exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RM_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.fired_any) begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = SCAN_SELECT;
                        state_next     = ST_SEL_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SEL_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.sel_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = SCAN_SELECT;
                        state_next     = ST_SEL_SCAN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/tqs_datapath.sv
// Datapath of the timer queue scheduler: slot memory, valid/cancel/fired flags,
// scan pipeline, id counter and output register. Uses tqs_pkg.
`timescale 1ns / 1ps
module tqs_datapath import tqs_pkg::*; #(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        logic                   periodic;
        logic [ID_W-1:0]        id;
        logic [PERIOD_BITS-1:0] period;
        logic [PERIOD_BITS-1:0] rem;
    } slot_t;

    slot_t mem [MAX_TASKS];

    logic [PERIOD_BITS-1:0] per_cap_reg;
    logic                   periodic_cap_reg;
    logic [ID_W-1:0]        tid_cap_reg;
    logic [PERIOD_BITS-1:0] per_in;
    logic [PERIOD_BITS-1:0] per_next;

    logic [MAX_TASKS-1:0] valid_reg;
    logic [MAX_TASKS-1:0] cancel_reg;
    logic [MAX_TASKS-1:0] fired_reg;
    logic [ID_W-1:0]      next_id_reg;

    scan_mode_t       mode_reg;
    logic             scan_active_reg;
    logic [CNT_W-1:0] iss_cnt_reg;
    logic             proc_vld_reg;
    logic [IDX_W-1:0] proc_idx_reg;
    slot_t            rd_word_reg;
    logic             issuing;

    logic             best_found_reg;
    logic [ID_W-1:0]  best_id_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [MAX_TASKS-1:0] best_mask;
    logic             sel_last;

    logic             table_full;
    logic [IDX_W-1:0] free_idx;
    logic             add_ok;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;

    logic             rem_gt1;
    logic             p_valid;
    logic             p_cancel;

    logic              m_tvalid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic              m_last_reg;
    logic              out_free;

    // period field mapped to PERIOD_BITS, zero promoted to one
    always_comb begin
        per_in = '0;
        for (int i = 0; i < PERIOD_BITS; i++) begin
            if (i < PER_W) begin
                per_in[i] = s_tdata[PER_LSB + i];
            end
        end
        per_next = (per_in == '0) ? PERIOD_BITS'(1) : per_in;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            per_cap_reg      <= per_next;
            periodic_cap_reg <= s_tdata[PERIODIC_BIT];
            tid_cap_reg      <= s_tdata[TID_LSB +: ID_W];
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign table_full = &valid_reg;
    assign add_ok     = cmd.add_exec && !table_full;

    // scan pipeline: issue read, then process one slot per cycle
    assign issuing  = scan_active_reg && (iss_cnt_reg != CNT_W'(MAX_TASKS));
    assign p_valid  = valid_reg[proc_idx_reg];
    assign p_cancel = cancel_reg[proc_idx_reg];
    assign rem_gt1  = rd_word_reg.rem > PERIOD_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            iss_cnt_reg     <= '0;
            proc_vld_reg    <= 1'b0;
            mode_reg        <= SCAN_REMOVE;
        end else begin
            proc_vld_reg <= issuing;
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
                iss_cnt_reg     <= '0;
                mode_reg        <= cmd.mode;
            end else if (sts.scan_done) begin
                scan_active_reg <= 1'b0;
            end else if (issuing) begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issuing) begin
            rd_word_reg  <= mem[iss_cnt_reg[IDX_W-1:0]];
            proc_idx_reg <= iss_cnt_reg[IDX_W-1:0];
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = proc_idx_reg;
        mem_wdata = rd_word_reg;
        if (add_ok) begin
            mem_we             = 1'b1;
            mem_waddr          = free_idx;
            mem_wdata.periodic = periodic_cap_reg;
            mem_wdata.id       = next_id_reg;
            mem_wdata.period   = per_cap_reg;
            mem_wdata.rem      = per_cap_reg;
        end else if (proc_vld_reg && mode_reg == SCAN_TICK && p_valid) begin
            if (rem_gt1) begin
                mem_we        = 1'b1;
                mem_wdata.rem = rd_word_reg.rem - PERIOD_BITS'(1);
            end else if (!p_cancel && rd_word_reg.periodic) begin
                mem_we        = 1'b1;
                mem_wdata.rem = rd_word_reg.period;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign best_mask = {{(MAX_TASKS-1){1'b0}}, 1'b1} << best_idx_reg;
    assign sel_last  = (fired_reg & ~best_mask) == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            cancel_reg  <= '0;
            fired_reg   <= '0;
            next_id_reg <= '0;
        end else begin
            if (add_ok) begin
                valid_reg[free_idx]  <= 1'b1;
                cancel_reg[free_idx] <= 1'b0;
                next_id_reg          <= next_id_reg + ID_W'(1);
            end
            if (proc_vld_reg) begin
                case (mode_reg)
                    SCAN_REMOVE: begin
                        if (p_valid && !p_cancel && rd_word_reg.id == tid_cap_reg) begin
                            cancel_reg[proc_idx_reg] <= 1'b1;
                        end
                    end
                    SCAN_TICK: begin
                        if (p_valid && !rem_gt1) begin
                            if (p_cancel) begin
                                valid_reg[proc_idx_reg]  <= 1'b0;
                                cancel_reg[proc_idx_reg] <= 1'b0;
                            end else begin
                                fired_reg[proc_idx_reg] <= 1'b1;
                                if (!rd_word_reg.periodic) begin
                                    valid_reg[proc_idx_reg] <= 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                fired_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // minimum id among fired slots; strict compare keeps lower slot on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            best_found_reg <= 1'b0;
        end else if (proc_vld_reg && mode_reg == SCAN_SELECT && fired_reg[proc_idx_reg]) begin
            if (!best_found_reg || rd_word_reg.id < best_id_reg) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_vld_reg && mode_reg == SCAN_SELECT && fired_reg[proc_idx_reg]) begin
            if (!best_found_reg || rd_word_reg.id < best_id_reg) begin
                best_id_reg  <= rd_word_reg.id;
                best_idx_reg <= proc_idx_reg;
            end
        end
    end

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.add_exec || cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_exec) begin
            m_kind_reg <= table_full ? EV_FULL : EV_ADDED;
            m_id_reg   <= table_full ? '0 : next_id_reg;
            m_last_reg <= 1'b1;
        end else if (cmd.emit) begin
            m_kind_reg <= EV_FIRED;
            m_id_reg   <= best_id_reg;
            m_last_reg <= sel_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-ID_W){1'b0}}, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign sts.scan_done = scan_active_reg && !issuing && !proc_vld_reg;
    assign sts.fired_any = |fired_reg;
    assign sts.out_free  = out_free;
    assign sts.sel_last  = sel_last;

endmodule

### rtl/core/timer_queue_scheduler.sv
// Timer queue scheduler top level: tqs_ctrl sequencer plus tqs_datapath.
// Add: the result goes into the output register once that register is free.
// Remove: one scan over the slot memory. Tick: one countdown scan, then for each
// fired task a minimum-id search over the slot memory (one slot a cycle).
// One input transaction at a time. aresetn (synchronous) clears all slot flags
// and the id counter, which empties every slot; no clearing pass is needed.
`timescale 1ns / 1ps
module timer_queue_scheduler import tqs_pkg::*; #(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // period_ticks[23:0], is_periodic[24], task_id[55:25]
    input  logic [OP_W-1:0]      s_tuser,  // op[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // task_id_out[30:0], zero pad[31]
    output logic [KIND_W-1:0]    m_tuser,  // event_kind[1:0]
    output logic                 m_tlast   // last
);

    cmd_t cmd;
    sts_t sts;

    tqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    tqs_datapath #(
        .MAX_TASKS   (MAX_TASKS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/core/tqs_checker.sv
// Port-level checks for timer_queue_scheduler, bound to the top level.
// Uses tqs_pkg.
`timescale 1ns / 1ps
module tqs_port_checker import tqs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]    m_tuser,
    input logic                 m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_add_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_FIRED |-> m_tlast)
        else $error("add answer without last");

    a_full_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_FULL |-> m_tdata == '0)
        else $error("rejected add carries nonzero id");

    a_add_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_ADD |=> !s_tready)
        else $error("input taken while add in progress");

endmodule

bind timer_queue_scheduler tqs_port_checker u_tqs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### test/tqs_checker.sv
// Checker for timer_queue_scheduler: watches the input and report streams, keeps its
// own copy of the timer table and compares every report with the predicted one.
// Depends on tqs_pkg.
`timescale 1ns / 1ps
module tqs_checker import tqs_pkg::*; #(
    parameter int MAX_TASKS   = MAX_TASKS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   errors,
    output int                   outstanding
);

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   tid;
        logic              last;
    } report_t;

    report_t          reports_q[$];

    bit               slot_live [MAX_TASKS];
    bit               slot_rep  [MAX_TASKS];
    bit               slot_dead [MAX_TASKS];
    logic [ID_W-1:0]  slot_tid  [MAX_TASKS];
    logic [PER_W-1:0] slot_len  [MAX_TASKS];
    logic [PER_W-1:0] slot_left [MAX_TASKS];
    logic [ID_W-1:0]  next_tid;

    task automatic predict_add(input logic [PER_W-1:0] per, input logic rep);
        logic [63:0]      mask;
        logic [PER_W-1:0] len;
        int               free_slot;
        report_t          r;
        mask = (64'd1 << PERIOD_BITS) - 64'd1;
        len = per & mask[PER_W-1:0];
        if (len == '0) len = PER_W'(1);
        free_slot = -1;
        for (int s = 0; s < MAX_TASKS; s++) begin
            if (!slot_live[s] && free_slot < 0) free_slot = s;
        end
        r.last = 1'b1;
        if (free_slot < 0) begin
            r.kind = EV_FULL;
            r.tid = '0;
        end else begin
            slot_live[free_slot] = 1'b1;
            slot_dead[free_slot] = 1'b0;
            slot_rep[free_slot] = rep;
            slot_tid[free_slot] = next_tid;
            slot_len[free_slot] = len;
            slot_left[free_slot] = len;
            r.kind = EV_ADDED;
            r.tid = next_tid;
            next_tid = next_tid + 1'b1;
        end
        reports_q.push_back(r);
    endtask

    task automatic predict_cancel(input logic [ID_W-1:0] tid);
        for (int s = 0; s < MAX_TASKS; s++) begin
            if (slot_live[s] && !slot_dead[s] && slot_tid[s] == tid) slot_dead[s] = 1'b1;
        end
    endtask

    task automatic predict_tick();
        logic [ID_W-1:0] fired [MAX_TASKS];
        logic [ID_W-1:0] v;
        int              n;
        int              j;
        report_t         r;
        n = 0;
        for (int s = 0; s < MAX_TASKS; s++) begin
            if (!slot_live[s]) continue;
            if (slot_left[s] > 1) begin
                slot_left[s] = slot_left[s] - 1'b1;
            end else if (slot_dead[s]) begin
                slot_live[s] = 1'b0;
                slot_dead[s] = 1'b0;
            end else begin
                fired[n] = slot_tid[s];
                n++;
                if (slot_rep[s]) slot_left[s] = slot_len[s];
                else slot_live[s] = 1'b0;
            end
        end
        // stable sort: equal ids stay in slot order
        for (int i = 1; i < n; i++) begin
            v = fired[i];
            j = i - 1;
            while (j >= 0 && fired[j] > v) begin
                fired[j + 1] = fired[j];
                j--;
            end
            fired[j + 1] = v;
        end
        for (int i = 0; i < n; i++) begin
            r.kind = EV_FIRED;
            r.tid = fired[i];
            r.last = (i == n - 1);
            reports_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        report_t want;
        if (!aresetn) begin
            for (int s = 0; s < MAX_TASKS; s++) begin
                slot_live[s] = 1'b0;
                slot_dead[s] = 1'b0;
            end
            next_tid = '0;
            reports_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (reports_q.size() == 0) begin
                    $display("%0t: unexpected report: kind=%0d tdata=%h last=%0d",
                             $time, m_tuser, m_tdata, m_tlast);
                    errors <= errors + 1;
                end else begin
                    want = reports_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== M_TDATA_W'(want.tid) ||
                        m_tlast !== want.last) begin
                        $display({"%0t: report mismatch: expected kind=%0d id=%0d last=%0d,",
                                  " got kind=%0d tdata=%h last=%0d"},
                                 $time, want.kind, want.tid, want.last,
                                 m_tuser, m_tdata, m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_ADD:    predict_add(s_tdata[PER_LSB +: PER_W], s_tdata[PERIODIC_BIT]);
                    OP_REMOVE: predict_cancel(s_tdata[TID_LSB +: ID_W]);
                    OP_TICK:   predict_tick();
                    default: ;
                endcase
            end
        end
        outstanding <= reports_q.size();
    end

endmodule

### test/timer_queue_scheduler_tb.sv
// Testbench top for timer_queue_scheduler: clock, reset, add/remove/tick stimulus with
// random gaps and back-pressure, watchdog and verdict. Needs tqs_pkg and tqs_checker.
`timescale 1ns / 1ps
module timer_queue_scheduler_tb;
    import tqs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 37;
    localparam int RANDOM_ITEMS   = 405;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int adds_sent    = 0;
    bit steady       = 1'b0;
    bit hold_req     = 1'b0;

    timer_queue_scheduler u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tqs_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timer_queue_scheduler_tb NOT OK");
            $finish;
        end
    end

    // report side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PER_W-1:0] per,
                             input logic rep, input logic [ID_W-1:0] tid);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {tid, rep, per};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_ADD) adds_sent++;
    endtask

    initial begin
        int               sent;
        int               pick;
        int               back;
        logic [PER_W-1:0] per;
        logic [ID_W-1:0]  tid;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        send_item(OP_TICK, '1, 1'b1, '1);        // empty table
        send_item(OP_UNUSED, '1, 1'b1, '1);      // ignored op
        send_item(OP_REMOVE, '0, 1'b0, '1);      // unknown id
        send_item(OP_ADD, '1, 1'b0, '0);         // id 0, longest delay
        send_item(OP_ADD, '0, 1'b1, '1);         // id 1, zero period -> 1, periodic
        send_item(OP_TICK, '0, 1'b0, '0);        // id 1 fires
        send_item(OP_REMOVE, '0, 1'b0, ID_W'(1));
        send_item(OP_TICK, '0, 1'b0, '0);        // id 1 due but cancelled: dropped
        for (int i = 0; i < 15; i++) send_item(OP_ADD, PER_W'(2), i[0], ID_W'($urandom()));
        send_item(OP_ADD, PER_W'(3), 1'b1, '0);  // table full
        send_item(OP_REMOVE, '0, 1'b0, ID_W'(4));
        send_item(OP_TICK, '0, 1'b0, '0);
        send_item(OP_TICK, '0, 1'b0, '0);        // burst of fires, id 4 dropped

        // random
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 100) hold_req = 1'b1;
            steady = (sent >= 150 && sent < 230);
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_item(OP_UNUSED, PER_W'($urandom()), 1'($urandom()), ID_W'($urandom()));
            end else if (pick < 40) begin
                per = ($urandom_range(9) == 0) ? PER_W'($urandom_range(40, 13))
                                               : PER_W'($urandom_range(8));
                send_item(OP_ADD, per, ($urandom_range(99) < 40), ID_W'($urandom()));
            end else if (pick < 60) begin
                if (adds_sent > 0 && $urandom_range(99) < 70) begin
                    back = $urandom_range((adds_sent > 24) ? 24 : adds_sent - 1);
                    tid = ID_W'(adds_sent - 1 - back);
                end else begin
                    tid = ID_W'($urandom());
                end
                send_item(OP_REMOVE, PER_W'($urandom()), 1'($urandom()), tid);
            end else begin
                send_item(OP_TICK, PER_W'($urandom()), 1'($urandom()), ID_W'($urandom()));
            end
            sent++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) $display("timer_queue_scheduler_tb OK");
        else $display("timer_queue_scheduler_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/tqs_pkg.sv
rtl/core/tqs_ctrl.sv
rtl/core/tqs_datapath.sv
rtl/core/timer_queue_scheduler.sv
rtl/core/tqs_checker.sv
test/tqs_checker.sv
test/timer_queue_scheduler_tb.sv
